>>> sv/vebm_pkg.sv
// Shared constants and coordinate and address helpers for the voxel exposed-block marker.
package vebm_pkg;

  // Cube geometry
  localparam int EDGE  = 32;
  localparam int CW    = 5;                        // coordinate field width
  localparam int EW    = CW + 1;                   // coordinate width with one guard bit
  localparam int TW    = 2;                        // block type width
  localparam int CELLS = EDGE * EDGE * EDGE;
  localparam int AW    = $clog2(CELLS);

  // Stream payload widths
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 8;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Block type codes
  localparam logic [TW-1:0] TYPE_AIR = 2'd0;

  // Query sequence: center cell, then x+1, x-1, y+1, y-1, z+1, z-1
  localparam int SW = 3;
  localparam logic [SW-1:0] STEP_CENTER = 3'd0;
  localparam logic [SW-1:0] STEP_XP     = 3'd1;
  localparam logic [SW-1:0] STEP_XM     = 3'd2;
  localparam logic [SW-1:0] STEP_YP     = 3'd3;
  localparam logic [SW-1:0] STEP_YM     = 3'd4;
  localparam logic [SW-1:0] STEP_ZP     = 3'd5;
  localparam logic [SW-1:0] STEP_ZM     = 3'd6;
  localparam logic [SW-1:0] STEP_END    = 3'd7;

  // True when a guarded coordinate lies inside the cube (minus one wraps high)
  function automatic logic coord_in(input logic [EW-1:0] c);
    coord_in = int'(c) < EDGE;
  endfunction

  // Linear cell address: (x*EDGE + y)*EDGE + z
  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y,
                                               input logic [CW-1:0] z);
    cell_addr = (AW'(x) * AW'(EDGE) + AW'(y)) * AW'(EDGE) + AW'(z);
  endfunction

endpackage

>>> sv/vebm_ram.sv
// Single-port synchronous RAM with registered read data.
module vebm_ram #(
  parameter int AW = 15,
  parameter int DW = 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // One access per cycle: write or read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> sv/voxel_exposed_block_marker.sv
// Voxel store with six-neighbour exposure query on a single-port block RAM.
// A query reads the cell and its in-cube neighbours one after another through the
// single RAM port, then ST_DONE loads the output register; a write goes straight to ST_DONE.
// A new beat is taken only once the previous result is in the output register.
// Reset: clears control state and sets outside_is_air to 1; the RAM is not cleared,
// so a cell reads as garbage until it has been written.
module voxel_exposed_block_marker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [vebm_pkg::S_DATA_W-1:0] s_tdata,   // pos_x[4:0], pos_y[9:5], pos_z[14:10],
                                                   // new_type[16:15], zero pad
  input  logic                          s_tuser,   // command (0 write, 1 query)
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [vebm_pkg::M_DATA_W-1:0] m_tdata,   // cell_type[1:0], visible[2], zero pad
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data
);
  import vebm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_DONE} state_t;

  state_t          state;
  logic [CW-1:0]   px, py, pz;
  logic [SW-1:0]   step;
  logic            rd_pend;
  logic            rd_in;
  logic [SW-1:0]   rd_tag;
  logic [TW-1:0]   res_type;
  logic            res_vis;
  logic            outside_is_air;

  logic [CW-1:0]   in_x, in_y, in_z;
  logic [TW-1:0]   in_type;
  logic            in_ok;
  logic            accept;

  logic [EW-1:0]   nx, ny, nz;
  logic            n_in;
  logic            issue;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_addr;
  logic [TW-1:0]   ram_rdata;
  logic            nb_air;
  logic            out_free;

  // Input beat fields
  assign in_x    = s_tdata[CW-1:0];
  assign in_y    = s_tdata[2*CW-1:CW];
  assign in_z    = s_tdata[3*CW-1:2*CW];
  assign in_type = s_tdata[3*CW+TW-1:3*CW];
  assign in_ok   = coord_in({1'b0, in_x}) && coord_in({1'b0, in_y}) && coord_in({1'b0, in_z});

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Neighbour coordinate for the current step
  always_comb begin
    nx = {1'b0, px};
    ny = {1'b0, py};
    nz = {1'b0, pz};
    case (step)
      STEP_XP: nx = {1'b0, px} + EW'(1);
      STEP_XM: nx = {1'b0, px} - EW'(1);
      STEP_YP: ny = {1'b0, py} + EW'(1);
      STEP_YM: ny = {1'b0, py} - EW'(1);
      STEP_ZP: nz = {1'b0, pz} + EW'(1);
      STEP_ZM: nz = {1'b0, pz} - EW'(1);
      default: ;
    endcase
  end

  assign n_in  = coord_in(nx) && coord_in(ny) && coord_in(nz);
  assign issue = (state == ST_BUSY) && (step != STEP_END);

  // RAM port: writes at acceptance, reads while stepping through the query
  assign ram_we   = accept && (s_tuser == CMD_WRITE) && in_ok;
  assign ram_re   = issue && n_in;
  assign ram_addr = ram_we ? cell_addr(in_x, in_y, in_z)
                           : cell_addr(nx[CW-1:0], ny[CW-1:0], nz[CW-1:0]);

  vebm_ram #(.AW(AW), .DW(TW)) u_ram (
    .clk   (clk),
    .en    (ram_we || ram_re),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_type),
    .rdata (ram_rdata)
  );

  // A neighbour beyond the cube edge takes the register's verdict
  assign nb_air = rd_in ? (ram_rdata == TYPE_AIR) : outside_is_air;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      outside_is_air <= 1'b1;
    end else if (cfg_wr_en) begin
      outside_is_air <= cfg_wr_data;
    end
  end

  // Sequencer, read tracking and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= STEP_CENTER;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= issue;
      // ST_DONE reloads the output register itself
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            px      <= in_x;
            py      <= in_y;
            pz      <= in_z;
            step    <= STEP_CENTER;
            res_vis <= 1'b0;
            if (!in_ok) begin
              res_type <= TYPE_AIR;
              state    <= ST_DONE;
            end else if (s_tuser == CMD_WRITE) begin
              res_type <= in_type;
              state    <= ST_DONE;
            end else begin
              state <= ST_BUSY;
            end
          end
        end
        ST_BUSY: begin
          if (issue) begin
            rd_tag <= step;
            rd_in  <= n_in;
            step   <= step + SW'(1);
          end else begin
            state <= ST_DONE;
          end
          if (rd_pend) begin
            if (rd_tag == STEP_CENTER) begin
              res_type <= ram_rdata;
            end else begin
              res_vis <= res_vis || nb_air;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(M_DATA_W-TW-1){1'b0}}, res_vis, res_type};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // RAM is written only on an accepted beat, never while a query is stepping
  a_we_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_IDLE)
    else $error("RAM write outside idle");

  // Every issued read is consumed in the next cycle while still busy
  a_rd_consumed: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> rd_pend && state == ST_BUSY)
    else $error("RAM read not consumed");

  // A result is only loaded when the output slot is free
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> state == ST_DONE)
    else $error("result overran output register");

endmodule

>>> test/voxel_exposed_block_marker_tb.sv
// Self-checking testbench for the voxel exposed-block marker: stream driver, monitor, predictor.
`timescale 1ns / 100ps

module voxel_exposed_block_marker_tb;
  import vebm_pkg::*;

  // Solid block type codes (air comes from the package)
  localparam logic [TW-1:0] TYPE_GRASS = 2'd1;
  localparam logic [TW-1:0] TYPE_STONE = 2'd2;
  localparam logic [TW-1:0] TYPE_OTHER = 2'd3;

  localparam int STALL_LIMIT  = 2000;  // cycles without any beat before giving up
  localparam int DRAIN_CYCLES = 20;    // wait before the final check for results that never arrived
  localparam int LONG_HOLD    = 300;   // receiver back-pressure stretch

  typedef struct packed {
    logic          cmd;
    logic [CW-1:0] x, y, z;
    logic [TW-1:0] new_type;
  } voxel_cmd_t;

  typedef struct packed {
    logic [TW-1:0] cell_type;
    logic          visible;
  } voxel_result_t;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                s_tvalid    = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata     = '0;
  logic                s_tuser     = 1'b0;
  logic                m_tvalid;
  logic                m_tready    = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_wr_en   = 1'b0;
  logic                cfg_wr_data = 1'b0;

  voxel_cmd_t    pending_cmds[$];     // commands not yet offered
  voxel_result_t expected_cells[$];   // predicted results in order
  logic [TW-1:0] shadow_cells [CELLS];
  bit            gen_written [CELLS]; // cells the stimulus has already set
  logic          outside_air = 1'b1;

  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  int   rx_hold_left = 0;
  logic in_taken     = 1'b0;          // input beat at the last rising edge
  int   err_count    = 0;
  int   idle_cycles  = 0;
  int   n_gen        = 0;
  int   n_writes     = 0;
  int   n_queries    = 0;
  int   n_visible    = 0;
  int   n_cfg        = 0;

  voxel_exposed_block_marker dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- prediction ----------------

  function automatic int cell_idx(int x, int y, int z);
    return (x * EDGE + y) * EDGE + z;
  endfunction

  // Neighbor counts as air; beyond the cube edge the register decides
  function automatic logic side_is_air(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= EDGE || y >= EDGE || z >= EDGE)
      return outside_air;
    return shadow_cells[cell_idx(x, y, z)] == TYPE_AIR;
  endfunction

  function automatic voxel_result_t predict_exposure(voxel_cmd_t c);
    voxel_result_t r;
    int x, y, z;
    x = c.x;
    y = c.y;
    z = c.z;
    if (c.cmd == CMD_WRITE) begin
      shadow_cells[cell_idx(x, y, z)] = c.new_type;
      r.cell_type = c.new_type;
      r.visible   = 1'b0;
    end else begin
      r.cell_type = shadow_cells[cell_idx(x, y, z)];
      r.visible   = side_is_air(x + 1, y, z) || side_is_air(x - 1, y, z) ||
                    side_is_air(x, y + 1, z) || side_is_air(x, y - 1, z) ||
                    side_is_air(x, y, z + 1) || side_is_air(x, y, z - 1);
    end
    return r;
  endfunction

  // ---------------- stimulus generation ----------------

  function automatic void push_cmd(logic cmd, int x, int y, int z, logic [TW-1:0] t);
    voxel_cmd_t c;
    c.cmd      = cmd;
    c.x        = CW'(x);
    c.y        = CW'(y);
    c.z        = CW'(z);
    c.new_type = t;
    pending_cmds = {pending_cmds, c};
    if (cmd == CMD_WRITE)
      gen_written[cell_idx(x, y, z)] = 1'b1;
    n_gen++;
  endfunction

  // Mostly solid so that hidden cells show up often
  function automatic logic [TW-1:0] fill_type();
    return ($urandom_range(99) < 15) ? TYPE_AIR : TW'($urandom_range(3, 1));
  endfunction

  // Query a cell, first setting whatever of it and its in-cube neighbors is still unset
  function automatic void push_query(int x, int y, int z);
    int nx, ny, nz;
    for (int k = 0; k < 7; k++) begin
      nx = x + (k == 1) - (k == 2);
      ny = y + (k == 3) - (k == 4);
      nz = z + (k == 5) - (k == 6);
      if (nx >= 0 && ny >= 0 && nz >= 0 && nx < EDGE && ny < EDGE && nz < EDGE &&
          !gen_written[cell_idx(nx, ny, nz)])
        push_cmd(CMD_WRITE, nx, ny, nz, fill_type());
    end
    push_cmd(CMD_QUERY, x, y, z, TW'($urandom_range(3)));
  endfunction

  // Mostly a small cluster, so queries land on cells already set; some faces, some anywhere
  function automatic int pick_coord(int base);
    int sel;
    sel = $urandom_range(9);
    if (sel < 6)
      return base + $urandom_range(3);
    if (sel < 8)
      return $urandom_range(1) ? EDGE - 1 : 0;
    return $urandom_range(EDGE - 1);
  endfunction

  function automatic void fill_random(int count);
    int bx, by, bz, goal;
    goal = n_gen + count;
    bx   = $urandom_range(EDGE - 4);
    by   = $urandom_range(EDGE - 4);
    bz   = $urandom_range(EDGE - 4);
    while (n_gen < goal) begin
      // move the cluster now and then
      if ($urandom_range(39) == 0) begin
        bx = $urandom_range(EDGE - 4);
        by = $urandom_range(EDGE - 4);
        bz = $urandom_range(EDGE - 4);
      end
      if ($urandom_range(99) < 45)
        push_cmd(CMD_WRITE, pick_coord(bx), pick_coord(by), pick_coord(bz),
                 TW'($urandom_range(3)));
      else
        push_query(pick_coord(bx), pick_coord(by), pick_coord(bz));
    end
  endfunction

  // Hold the sender until every expected result is back
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || s_tvalid || expected_cells.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_outside_air(logic v);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    outside_air = v;
    n_cfg++;
  endtask

  // ---------------- input driver ----------------

  always @(negedge clk) begin
    voxel_cmd_t c;
    if (!rst && (!s_tvalid || in_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        c = pending_cmds.pop_front();
        s_tdata  <= S_DATA_W'({c.new_type, c.z, c.y, c.x});
        s_tuser  <= c.cmd;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- output back-pressure ----------------

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      m_tready     <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------- monitor and checker ----------------

  always @(posedge clk) begin
    voxel_cmd_t    c;
    voxel_result_t got, want;
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      // input beat: predict and queue
      if (s_tvalid && s_tready) begin
        c.cmd      = s_tuser;
        c.x        = s_tdata[4:0];
        c.y        = s_tdata[9:5];
        c.z        = s_tdata[14:10];
        c.new_type = s_tdata[16:15];
        want = predict_exposure(c);
        expected_cells = {expected_cells, want};
        if (c.cmd == CMD_WRITE) begin
          n_writes++;
        end else begin
          n_queries++;
          if (want.visible)
            n_visible++;
        end
      end
      // output beat: compare with oldest prediction
      if (m_tvalid && m_tready) begin
        got.cell_type = m_tdata[1:0];
        got.visible   = m_tdata[2];
        if (expected_cells.size() == 0) begin
          err_count++;
          $display("%0t: result with nothing expected: expected none, actual type %0d vis %0b",
                   $time, got.cell_type, got.visible);
        end else begin
          want = expected_cells.pop_front();
          if (got.cell_type !== want.cell_type) begin
            err_count++;
            $display("%0t: cell_type mismatch: expected %0d, actual %0d",
                     $time, want.cell_type, got.cell_type);
          end
          if (got.visible !== want.visible) begin
            err_count++;
            $display("%0t: visible mismatch: expected %0b, actual %0b",
                     $time, want.visible, got.visible);
          end
        end
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- test sequence ----------------

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, outside counts as air (reset value)
    tx_idle_pct = 11;
    rx_idle_pct = 49;
    // low corner: solid neighbors, exposed only through the cube faces
    push_cmd(CMD_WRITE, 0, 0, 0, TYPE_STONE);
    push_cmd(CMD_WRITE, 1, 0, 0, TYPE_STONE);
    push_cmd(CMD_WRITE, 0, 1, 0, TYPE_STONE);
    push_cmd(CMD_WRITE, 0, 0, 1, TYPE_GRASS);
    push_cmd(CMD_QUERY, 0, 0, 0, TYPE_OTHER);
    // high corner
    push_cmd(CMD_WRITE, 31, 31, 31, TYPE_GRASS);
    push_cmd(CMD_WRITE, 30, 31, 31, TYPE_OTHER);
    push_cmd(CMD_WRITE, 31, 30, 31, TYPE_OTHER);
    push_cmd(CMD_WRITE, 31, 31, 30, TYPE_STONE);
    push_cmd(CMD_QUERY, 31, 31, 31, TYPE_AIR);
    // interior cell fully enclosed, then one face opened, then own type air
    push_cmd(CMD_WRITE, 15, 15, 15, TYPE_OTHER);
    push_cmd(CMD_WRITE, 16, 15, 15, TYPE_STONE);
    push_cmd(CMD_WRITE, 14, 15, 15, TYPE_STONE);
    push_cmd(CMD_WRITE, 15, 16, 15, TYPE_STONE);
    push_cmd(CMD_WRITE, 15, 14, 15, TYPE_STONE);
    push_cmd(CMD_WRITE, 15, 15, 16, TYPE_STONE);
    push_cmd(CMD_WRITE, 15, 15, 14, TYPE_STONE);
    push_cmd(CMD_QUERY, 15, 15, 15, TYPE_STONE);
    push_cmd(CMD_WRITE, 15, 15, 16, TYPE_AIR);
    push_cmd(CMD_QUERY, 15, 15, 15, TYPE_GRASS);
    push_cmd(CMD_WRITE, 15, 15, 16, TYPE_GRASS);
    push_cmd(CMD_WRITE, 15, 15, 15, TYPE_AIR);
    push_cmd(CMD_QUERY, 15, 15, 15, TYPE_OTHER);
    wait_idle();

    // Same cells with the outside counted as solid
    write_outside_air(1'b0);
    push_cmd(CMD_QUERY, 0, 0, 0, TYPE_AIR);
    push_cmd(CMD_QUERY, 31, 31, 31, TYPE_OTHER);
    push_cmd(CMD_QUERY, 15, 15, 15, TYPE_STONE);
    wait_idle();

    // Random, slow receiver side traffic
    fill_random(120);
    wait_idle();

    // Random, outside is air, slow sender
    write_outside_air(1'b1);
    tx_idle_pct = 49;
    rx_idle_pct = 11;
    fill_random(120);
    wait_idle();

    // Random at full rate, with a long receiver stall to back up the input
    write_outside_air(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fill_random(130);
    @(posedge clk);
    rx_hold_left = LONG_HOLD;
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_cells.size() != 0) begin
      err_count++;
      $display("%0t: %0d results never arrived", $time, expected_cells.size());
    end
    $display("Covered %0d writes and %0d queries (%0d exposed), %0d outside_is_air writes,",
             n_writes, n_queries, n_visible, n_cfg);
    $display("  cube corners and faces, enclosed cells, and a long output stall.");
    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
sv/vebm_pkg.sv
sv/vebm_ram.sv
sv/voxel_exposed_block_marker.sv
test/voxel_exposed_block_marker_tb.sv
